// ===== rtl/mbr_pkg.sv =====
package mbr_pkg;

  localparam int BUFFER_BYTES_DEF  = 4096;
  localparam int MAX_READ_BITS_DEF = 32;

  localparam int          SEARCH_BITS  = 5 << 3;
  localparam logic [23:0] START_PREFIX = 24'h000001;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_CONSUME   = 3'd1,
    OP_PEEK      = 3'd2,
    OP_SKIP      = 3'd3,
    OP_ALIGN     = 3'd4,
    OP_SKIP_WHILE = 3'd5,
    OP_FIND      = 3'd6,
    OP_NO_PREFIX = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ===== rtl/mbr_store.sv =====
module mbr_store #(
  parameter int DEPTH = mbr_pkg::BUFFER_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/msb_first_bit_reader.sv =====
// Append, skip and align finish in the execute state. in_ready is high only when idle, so a
// new command is taken only once the last result is registered; a result waits while the
// output holds an untaken one. Consume, peek and the prefix test fetch a window of bytes
// through the single store read port. Skip-while reads, then checks each byte visited; start-code
// search reads and checks each byte scanned, then the code byte, as store read data is registered.
// Reset clears fill count, bit pointer and handshake state; the byte store is not cleared.
module msb_first_bit_reader #(
  parameter int BUFFER_BYTES  = mbr_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_opcode,
  input  logic [5:0]                        in_bit_count,
  input  logic [15:0]                       in_skip_amount,
  input  logic [7:0]                        in_byte_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [MAX_READ_BITS-1:0]          out_read_value,
  output logic [1:0]                        out_status,
  output logic                              out_found_flag,
  output logic [7:0]                        out_code_byte,
  output logic [$clog2(BUFFER_BYTES+1)-1:0] out_skipped_count
);

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int FW  = $clog2(BUFFER_BYTES + 1);
  localparam int PW  = FW + 3;
  localparam int IW  = FW + 1;
  localparam int NW  = $clog2(MAX_READ_BITS + 1);
  localparam int WB  = ((MAX_READ_BITS + 14) / 8 > 3) ? (MAX_READ_BITS + 14) / 8 : 3;
  localparam int WIN = WB * 8;
  localparam int CW  = $clog2(WB + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_FETCH, S_BITS, S_SW_RD, S_SW_CHK,
    S_F_RD, S_F_CHK, S_F_CODE_RD, S_F_CODE_CHK
  } state_t;

  state_t               state_r, state_nxt;
  mbr_pkg::op_t         op_r, op_nxt;
  logic [NW-1:0]        nbits_r, nbits_nxt;
  logic [15:0]          skip_r, skip_nxt;
  logic [7:0]           bval_r, bval_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WIN-1:0]       win_r, win_nxt;
  logic [1:0]           nload_r, nload_nxt;
  logic [FW-1:0]        count_r, count_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [MAX_READ_BITS-1:0] out_read_value_r, out_read_value_nxt;
  mbr_pkg::status_t         out_status_r, out_status_nxt;
  logic                     out_found_flag_r, out_found_flag_nxt;
  logic [7:0]               out_code_byte_r, out_code_byte_nxt;
  logic [FW-1:0]            out_skipped_count_r, out_skipped_count_nxt;

  logic [PW-1:0]            total_bits, avail, ptr_al;
  logic [IW-1:0]            al_idx, byte_idx, fill_x, rd_idx;
  logic [WIN-1:0]           win_shl;
  logic [MAX_READ_BITS-1:0] win_top;
  logic [7:0]               rd_data;
  logic                     mem_we;
  logic                     out_free;

  logic                     done;
  mbr_pkg::status_t         res_status;
  logic [MAX_READ_BITS-1:0] res_value;
  logic                     res_found;
  logic [7:0]               res_code;
  logic [FW-1:0]            res_count;
  logic [PW-1:0]            ptr_upd;
  logic [FW-1:0]            fill_upd;

  assign total_bits = PW'({fill_r, 3'b000});
  assign avail      = total_bits - ptr_r;
  assign ptr_al     = (ptr_r + PW'(7)) & ~PW'(7);
  assign al_idx     = IW'(ptr_al[PW-1:3]);
  assign byte_idx   = IW'(ptr_r[PW-1:3]);
  assign fill_x     = IW'(fill_r);
  assign win_shl    = win_r << ptr_r[2:0];
  assign win_top    = win_shl[WIN-1 -: MAX_READ_BITS];
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);

  always_comb begin
    case (state_r)
      S_FETCH:                    rd_idx = j_r + IW'(cnt_r);
      S_F_CODE_RD, S_F_CODE_CHK:  rd_idx = j_r + IW'(1);
      default:                    rd_idx = j_r;
    endcase
  end

  assign mem_we = (state_r == S_EXEC) && (op_r == mbr_pkg::OP_APPEND) &&
                  (fill_r < FW'(BUFFER_BYTES)) && out_free;

  mbr_store #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (bval_r),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    nbits_nxt = nbits_r;
    skip_nxt  = skip_r;
    bval_nxt  = bval_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    win_nxt   = win_r;
    nload_nxt = nload_r;
    count_nxt = count_r;

    out_valid_nxt         = out_valid_r && !out_ready;
    out_read_value_nxt    = out_read_value_r;
    out_status_nxt        = out_status_r;
    out_found_flag_nxt    = out_found_flag_r;
    out_code_byte_nxt     = out_code_byte_r;
    out_skipped_count_nxt = out_skipped_count_r;

    done       = 1'b0;
    res_status = mbr_pkg::ST_OK;
    res_value  = '0;
    res_found  = 1'b0;
    res_code   = 8'h00;
    res_count  = '0;
    ptr_upd    = ptr_r;
    fill_upd   = fill_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = mbr_pkg::op_t'(in_opcode);
          nbits_nxt = (in_bit_count > 6'(MAX_READ_BITS)) ? NW'(MAX_READ_BITS)
                                                         : NW'(in_bit_count);
          skip_nxt  = in_skip_amount;
          bval_nxt  = in_byte_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          mbr_pkg::OP_APPEND: begin
            done = 1'b1;
            if (fill_r >= FW'(BUFFER_BYTES)) begin
              res_status = mbr_pkg::ST_FULL;
            end else begin
              fill_upd = fill_r + FW'(1);
            end
          end
          mbr_pkg::OP_CONSUME, mbr_pkg::OP_PEEK: begin
            if (avail < PW'(nbits_r)) begin
              done       = 1'b1;
              res_status = mbr_pkg::ST_SHORT;
            end else begin
              j_nxt     = byte_idx;
              cnt_nxt   = '0;
              state_nxt = S_FETCH;
            end
          end
          mbr_pkg::OP_SKIP: begin
            done = 1'b1;
            if (avail < skip_r) begin
              res_status = mbr_pkg::ST_SHORT;
            end else begin
              ptr_upd = ptr_r + PW'(skip_r);
            end
          end
          mbr_pkg::OP_ALIGN: begin
            done    = 1'b1;
            ptr_upd = ptr_al;
          end
          mbr_pkg::OP_SKIP_WHILE: begin
            j_nxt     = al_idx;
            count_nxt = '0;
            state_nxt = S_SW_RD;
          end
          mbr_pkg::OP_FIND: begin
            if (al_idx + IW'(5) > fill_x) begin
              done       = 1'b1;
              res_status = mbr_pkg::ST_SHORT;
            end else begin
              j_nxt     = al_idx;
              nload_nxt = 2'd0;
              state_nxt = S_F_RD;
            end
          end
          default: begin
            if (avail < PW'(mbr_pkg::SEARCH_BITS)) begin
              done       = 1'b1;
              res_status = mbr_pkg::ST_SHORT;
            end else begin
              j_nxt     = al_idx;
              cnt_nxt   = '0;
              state_nxt = S_FETCH;
            end
          end
        endcase
      end
      S_FETCH: begin
        if (cnt_r != '0) begin
          win_nxt = {win_r[WIN-9:0], rd_data};
        end
        if (cnt_r == CW'(WB)) begin
          state_nxt = S_BITS;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_BITS: begin
        done = 1'b1;
        if (op_r == mbr_pkg::OP_NO_PREFIX) begin
          res_found = (win_r[WIN-1 -: 24] != mbr_pkg::START_PREFIX);
        end else begin
          res_value = win_top >> (NW'(MAX_READ_BITS) - nbits_r);
          if (op_r == mbr_pkg::OP_CONSUME) begin
            ptr_upd = ptr_r + PW'(nbits_r);
          end
        end
      end
      S_SW_RD: begin
        if (j_r < fill_x) begin
          state_nxt = S_SW_CHK;
        end else begin
          done      = 1'b1;
          res_count = count_r;
          ptr_upd   = PW'({j_r, 3'b000});
        end
      end
      S_SW_CHK: begin
        if (rd_data == bval_r) begin
          j_nxt     = j_r + IW'(1);
          count_nxt = count_r + FW'(1);
          state_nxt = S_SW_RD;
        end else begin
          done      = 1'b1;
          res_count = count_r;
          ptr_upd   = PW'({j_r, 3'b000});
        end
      end
      S_F_RD: begin
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (nload_r != 2'd2) begin
          win_nxt   = {win_r[WIN-9:0], rd_data};
          nload_nxt = nload_r + 2'd1;
          j_nxt     = j_r + IW'(1);
          state_nxt = S_F_RD;
        end else if ({win_r[15:0], rd_data} == mbr_pkg::START_PREFIX) begin
          state_nxt = S_F_CODE_RD;
        end else if (j_r + IW'(4) <= fill_x) begin
          win_nxt   = {win_r[WIN-9:0], rd_data};
          j_nxt     = j_r + IW'(1);
          state_nxt = S_F_RD;
        end else begin
          done    = 1'b1;
          ptr_upd = PW'({j_r - IW'(1), 3'b000});
        end
      end
      S_F_CODE_RD: begin
        state_nxt = S_F_CODE_CHK;
      end
      S_F_CODE_CHK: begin
        done      = 1'b1;
        res_found = 1'b1;
        res_code  = rd_data;
        ptr_upd   = PW'({j_r + IW'(2), 3'b000});
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done && out_free) begin
      state_nxt             = S_IDLE;
      ptr_nxt               = ptr_upd;
      fill_nxt              = fill_upd;
      out_valid_nxt         = 1'b1;
      out_read_value_nxt    = res_value;
      out_status_nxt        = res_status;
      out_found_flag_nxt    = res_found;
      out_code_byte_nxt     = res_code;
      out_skipped_count_nxt = res_count;
    end else if (done) begin
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
    end
    op_r                <= op_nxt;
    nbits_r             <= nbits_nxt;
    skip_r              <= skip_nxt;
    bval_r              <= bval_nxt;
    j_r                 <= j_nxt;
    cnt_r               <= cnt_nxt;
    win_r               <= win_nxt;
    nload_r             <= nload_nxt;
    count_r             <= count_nxt;
    out_read_value_r    <= out_read_value_nxt;
    out_status_r        <= out_status_nxt;
    out_found_flag_r    <= out_found_flag_nxt;
    out_code_byte_r     <= out_code_byte_nxt;
    out_skipped_count_r <= out_skipped_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_read_value_r;
  assign out_status        = out_status_r;
  assign out_found_flag    = out_found_flag_r;
  assign out_code_byte     = out_code_byte_r;
  assign out_skipped_count = out_skipped_count_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(BUFFER_BYTES))
    else $error("fill count beyond store depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= total_bits)
    else $error("bit pointer beyond buffered data");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (fill_r == $past(fill_r) + FW'(1)) && out_valid_r &&
               (out_status_r == mbr_pkg::ST_OK))
    else $error("store write without matching fill advance");

  a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != mbr_pkg::ST_OK) |->
      !out_found_flag_r && (out_read_value_r == '0))
    else $error("failed command reports data");

endmodule

// ===== bench/tb_msb_first_bit_reader.sv =====
module tb_msb_first_bit_reader;

  localparam int BUF_BYTES   = mbr_pkg::BUFFER_BYTES_DEF;
  localparam int READ_MAX    = mbr_pkg::MAX_READ_BITS_DEF;
  localparam int CNT_W       = $clog2(BUF_BYTES + 1);
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [READ_MAX-1:0] value;
    mbr_pkg::status_t    status;
    logic                found;
    logic [7:0]          code;
    logic [CNT_W-1:0]    skipped;
  } reply_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [2:0]          in_opcode;
  logic [5:0]          in_bit_count;
  logic [15:0]         in_skip_amount;
  logic [7:0]          in_byte_value;
  logic                out_valid;
  logic                out_ready;
  logic [READ_MAX-1:0] out_read_value;
  logic [1:0]          out_status;
  logic                out_found_flag;
  logic [7:0]          out_code_byte;
  logic [CNT_W-1:0]    out_skipped_count;

  logic [7:0] shadow_bytes [BUF_BYTES];
  int         shadow_fill;
  int         shadow_bitpos;
  reply_t     pending_replies [$];

  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  msb_first_bit_reader i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_bit_count      (in_bit_count),
    .in_skip_amount    (in_skip_amount),
    .in_byte_value     (in_byte_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_status        (out_status),
    .out_found_flag    (out_found_flag),
    .out_code_byte     (out_code_byte),
    .out_skipped_count (out_skipped_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int bits_left(int pos);
    int total;
    total = shadow_fill * 8;
    return (pos <= total) ? total - pos : 0;
  endfunction

  function automatic int round_up_byte(int pos);
    return ((pos + 7) / 8) * 8;
  endfunction

  function automatic logic [7:0] byte_from(int idx);
    return (idx < BUF_BYTES) ? shadow_bytes[idx] : 8'h00;
  endfunction

  function automatic bit prefix_here(int idx);
    return {byte_from(idx), byte_from(idx + 1), byte_from(idx + 2)} ==
           mbr_pkg::START_PREFIX;
  endfunction

  function automatic reply_t compute_reply(mbr_pkg::op_t op, logic [5:0] count_in,
                                           logic [15:0] skip, logic [7:0] bval);
    reply_t     r;
    int         nbits;
    int         pos;
    int         idx;
    logic [7:0] b;
    r     = '0;
    nbits = (int'(count_in) > READ_MAX) ? READ_MAX : int'(count_in);
    case (op)
      mbr_pkg::OP_APPEND: begin
        if (shadow_fill >= BUF_BYTES) begin
          r.status = mbr_pkg::ST_FULL;
        end else begin
          shadow_bytes[shadow_fill] = bval;
          shadow_fill++;
        end
      end
      mbr_pkg::OP_CONSUME, mbr_pkg::OP_PEEK: begin
        if (bits_left(shadow_bitpos) < nbits) begin
          r.status = mbr_pkg::ST_SHORT;
        end else begin
          for (int i = 0; i < nbits; i++) begin
            pos     = shadow_bitpos + i;
            b       = byte_from(pos / 8);
            r.value = {r.value[READ_MAX-2:0], b[7 - pos % 8]};
          end
          if (op == mbr_pkg::OP_CONSUME) shadow_bitpos += nbits;
        end
      end
      mbr_pkg::OP_SKIP: begin
        if (bits_left(shadow_bitpos) < int'(skip)) r.status = mbr_pkg::ST_SHORT;
        else shadow_bitpos += int'(skip);
      end
      mbr_pkg::OP_ALIGN: begin
        shadow_bitpos = round_up_byte(shadow_bitpos);
      end
      mbr_pkg::OP_SKIP_WHILE: begin
        shadow_bitpos = round_up_byte(shadow_bitpos);
        while (bits_left(shadow_bitpos) >= 8 && byte_from(shadow_bitpos / 8) == bval) begin
          shadow_bitpos += 8;
          r.skipped++;
        end
      end
      mbr_pkg::OP_FIND: begin
        pos = round_up_byte(shadow_bitpos);
        if (bits_left(pos) < mbr_pkg::SEARCH_BITS) begin
          r.status = mbr_pkg::ST_SHORT;
        end else begin
          while (!r.found && bits_left(pos) >= mbr_pkg::SEARCH_BITS) begin
            idx = pos / 8;
            if (prefix_here(idx)) begin
              r.found = 1'b1;
              r.code  = byte_from(idx + 3);
              pos     = (idx + 4) * 8;
            end else begin
              pos += 8;
            end
          end
          shadow_bitpos = pos;
        end
      end
      mbr_pkg::OP_NO_PREFIX: begin
        if (bits_left(shadow_bitpos) < mbr_pkg::SEARCH_BITS) r.status = mbr_pkg::ST_SHORT;
        else r.found = !prefix_here(round_up_byte(shadow_bitpos) / 8);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99, 0);
    if (r < 35) return 8'h00;
    if (r < 50) return 8'h01;
    if (r < 58) return 8'hFF;
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [5:0] pick_bit_count();
    if ($urandom_range(9, 0) == 0) return 6'($urandom_range(63, 33));
    return 6'($urandom_range(32, 0));
  endfunction

  function automatic logic [15:0] pick_skip();
    int r;
    int lim;
    r   = $urandom_range(99, 0);
    lim = bits_left(shadow_bitpos) + 8;
    if (lim > 65535) lim = 65535;
    if (r < 60) return 16'($urandom_range(40, 0));
    if (r < 85) return 16'($urandom_range(lim, 0));
    return 16'($urandom_range(65535, 0));
  endfunction

  // enter and leave at a falling edge
  task automatic issue_cmd(input mbr_pkg::op_t op, input logic [5:0] cnt,
                           input logic [15:0] skip, input logic [7:0] bval);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_bit_count   = cnt;
    in_skip_amount = skip;
    in_byte_value  = bval;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(compute_reply(op, cnt, skip, bval));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_for_replies();
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue_random_cmd();
    int         pick;
    int         at;
    logic [7:0] bval;
    pick = $urandom_range(99, 0);
    if (pick < 28) begin
      issue_cmd(mbr_pkg::OP_APPEND, pick_bit_count(), pick_skip(), pick_byte());
    end else if (pick < 34) begin
      issue_cmd(mbr_pkg::OP_APPEND, pick_bit_count(), pick_skip(), 8'h00);
      issue_cmd(mbr_pkg::OP_APPEND, pick_bit_count(), pick_skip(), 8'h00);
      issue_cmd(mbr_pkg::OP_APPEND, pick_bit_count(), pick_skip(), 8'h01);
      issue_cmd(mbr_pkg::OP_APPEND, pick_bit_count(), pick_skip(),
                8'($urandom_range(255, 0)));
    end else if (pick < 46) begin
      issue_cmd(mbr_pkg::OP_CONSUME, pick_bit_count(), pick_skip(), pick_byte());
    end else if (pick < 56) begin
      issue_cmd(mbr_pkg::OP_PEEK, pick_bit_count(), pick_skip(), pick_byte());
    end else if (pick < 64) begin
      issue_cmd(mbr_pkg::OP_SKIP, pick_bit_count(), pick_skip(), pick_byte());
    end else if (pick < 70) begin
      issue_cmd(mbr_pkg::OP_ALIGN, pick_bit_count(), pick_skip(), pick_byte());
    end else if (pick < 80) begin
      at = round_up_byte(shadow_bitpos) / 8;
      if (at < shadow_fill && $urandom_range(1, 0) == 1) bval = shadow_bytes[at];
      else bval = pick_byte();
      issue_cmd(mbr_pkg::OP_SKIP_WHILE, pick_bit_count(), pick_skip(), bval);
    end else if (pick < 90) begin
      issue_cmd(mbr_pkg::OP_FIND, pick_bit_count(), pick_skip(), pick_byte());
    end else begin
      issue_cmd(mbr_pkg::OP_NO_PREFIX, pick_bit_count(), pick_skip(), pick_byte());
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    issue_cmd(mbr_pkg::OP_CONSUME, 6'd1, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_PEEK, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_SKIP, 6'd0, 16'hFFFF, 8'h00);
    issue_cmd(mbr_pkg::OP_ALIGN, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_SKIP_WHILE, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_FIND, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_NO_PREFIX, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'hA5);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h01);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'hB3);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'hFF);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'hFF);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h01);
    issue_cmd(mbr_pkg::OP_PEEK, 6'd63, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_CONSUME, 6'd3, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_NO_PREFIX, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_SKIP_WHILE, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_SKIP, 6'd0, 16'd8, 8'h00);
    issue_cmd(mbr_pkg::OP_CONSUME, 6'd8, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_SKIP_WHILE, 6'd0, 16'd0, 8'hFF);
    issue_cmd(mbr_pkg::OP_FIND, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h42);
    issue_cmd(mbr_pkg::OP_APPEND, 6'd0, 16'd0, 8'h7E);
    issue_cmd(mbr_pkg::OP_FIND, 6'd0, 16'd0, 8'h00);
    wait_for_replies();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 62 : (p == 3) ? 24 : 0;
      recv_stall_pct = (p == 2) ? 62 : (p == 3) ? 24 : 0;
      repeat (225) issue_random_cmd();
      wait_for_replies();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_request = 400;
    @(negedge clk);
    repeat (40) issue_random_cmd();
    wait_for_replies();
  endtask

  task automatic test_data_end();
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    repeat (80) issue_random_cmd();
    issue_cmd(mbr_pkg::OP_SKIP, 6'd0, 16'(bits_left(shadow_bitpos)), 8'h00);
    issue_cmd(mbr_pkg::OP_CONSUME, 6'd1, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_PEEK, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_SKIP_WHILE, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_FIND, 6'd0, 16'd0, 8'h00);
    issue_cmd(mbr_pkg::OP_NO_PREFIX, 6'd0, 16'd0, 8'h00);
    wait_for_replies();
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_read_value !== want.value) begin
          $error("read_value: expected %h, got %h", want.value, out_read_value);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_found_flag !== want.found) begin
          $error("found_flag: expected %0d, got %0d", want.found, out_found_flag);
          fail_count++;
        end
        if (out_code_byte !== want.code) begin
          $error("code_byte: expected %h, got %h", want.code, out_code_byte);
          fail_count++;
        end
        if (out_skipped_count !== want.skipped) begin
          $error("skipped_count: expected %0d, got %0d", want.skipped, out_skipped_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = mbr_pkg::OP_APPEND;
    in_bit_count   = '0;
    in_skip_amount = '0;
    in_byte_value  = '0;
    out_ready      = 1'b0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    shadow_fill    = 0;
    shadow_bitpos  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phases();
    test_backpressure();
    test_data_end();
    wait_for_replies();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== msb_first_bit_reader.f =====
rtl/mbr_pkg.sv
rtl/mbr_store.sv
rtl/msb_first_bit_reader.sv
bench/tb_msb_first_bit_reader.sv
